### rtl/multiword_restoring_divider_macros.svh
// Assertion macros for the multiword restoring divider.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MULTIWORD_RESTORING_DIVIDER_MACROS_SVH
`define MULTIWORD_RESTORING_DIVIDER_MACROS_SVH

// same-cycle implication, disabled in reset
`define MRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mrd_pkg.sv
// Package for the multiword restoring divider: default sizes and width helpers.
// No dependencies.
`timescale 1ns / 1ps

package mrd_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned NUM_WORDS_DEF = 2;
  localparam int unsigned FIELD_BITS    = 64;

  typedef struct packed {
    logic valid;
    logic ready;
  } mrd_hs_t;

  function automatic int unsigned op_bits(input int unsigned word_bits,
                                          input int unsigned word_cnt);
    int unsigned total;
    total = word_bits * word_cnt;
    return (total < FIELD_BITS) ? total : FIELD_BITS;
  endfunction

endpackage

### rtl/mrd_stage.sv
// One pipeline stage of the divider: decides one quotient bit by compare and subtract.
// Depends on mrd_pkg and multiword_restoring_divider_macros.svh.
`timescale 1ns / 1ps
`include "multiword_restoring_divider_macros.svh"

module mrd_stage
  import mrd_pkg::*;
#(
  parameter int unsigned OP_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  mrd_hs_t            up,       // valid from upstream, ready returned
  output logic               up_ready,
  input  logic [OP_BITS-1:0] rem_in,
  input  logic [OP_BITS-1:0] work_in,  // dividend bits out at top, quotient bits in at bottom
  input  logic [OP_BITS-1:0] den_in,
  input  logic               dbz_in,
  output logic               down_valid,
  input  logic               down_ready,
  output logic [OP_BITS-1:0] rem,
  output logic [OP_BITS-1:0] work,
  output logic [OP_BITS-1:0] den,
  output logic               dbz
);

  logic               valid;
  logic [OP_BITS:0]   shifted;
  logic [OP_BITS:0]   diff;
  logic               ge;
  logic [OP_BITS-1:0] rem_next;
  logic [OP_BITS-1:0] work_next;
  logic               load;

  assign shifted   = {rem_in, work_in[OP_BITS-1]};
  assign diff      = shifted - {1'b0, den_in};
  assign ge        = ~diff[OP_BITS];
  assign rem_next  = ge ? diff[OP_BITS-1:0] : shifted[OP_BITS-1:0];
  assign work_next = {work_in[OP_BITS-2:0], ge};

  assign up_ready   = ~valid | down_ready;
  assign load       = up.valid & up_ready;
  assign down_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= rem_next;
      work <= work_next;
      den  <= den_in;
      dbz  <= dbz_in;
    end
  end

  `MRD_ASSERT_NOW(a_rem_below_den, clk, rst, valid && (den != '0), rem < den, "partial remainder not below divisor")
  `MRD_ASSERT_NOW(a_dbz_zero_den, clk, rst, valid && dbz, den == '0, "zero-divisor flag with non-zero divisor")
  `MRD_ASSERT_NEXT(a_stall_holds, clk, rst, valid && !down_ready, valid && $stable(rem) && $stable(work), "stalled stage changed")

endmodule

### rtl/multiword_restoring_divider.sv
// Unsigned restoring divider: s_axis operands in, m_axis quotient and remainder out.
// Top level; depends on mrd_pkg and mrd_stage.
//
// s_axis carries one division per transaction: dividend and divisor in tdata.
// m_axis returns quotient and remainder in tdata and a zero-divisor flag in tuser.
// Operand width is WORD_BITS * NUM_WORDS, at most 64; higher input bits are ignored
// and higher result bits are zero.
// One stage per quotient bit, most significant first; each stage holds one wide
// subtract and compare.
// Throughput: one transaction per cycle while m_axis_tready is high.
// A zero divisor gives an all-ones quotient, the dividend as remainder and tuser set.
// When m_axis_tready is low the stages fill up behind the output register and
// s_axis_tready falls once all are full; nothing is dropped or repeated.
// Reset (rst, synchronous) clears every stage valid bit; data in flight is lost.
`timescale 1ns / 1ps

module multiword_restoring_divider
  import mrd_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned NUM_WORDS = NUM_WORDS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [2*FIELD_BITS-1:0] s_axis_tdata,   // dividend [63:0], divisor [127:64]
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [2*FIELD_BITS-1:0] m_axis_tdata,   // quotient [63:0], remainder [127:64]
  output logic                    m_axis_tuser    // divide_by_zero
);

  localparam int unsigned OP_BITS = op_bits(WORD_BITS, NUM_WORDS);

  logic               v     [OP_BITS+1];
  logic               rdy   [OP_BITS+1];
  logic [OP_BITS-1:0] rem_c [OP_BITS+1];
  logic [OP_BITS-1:0] work_c[OP_BITS+1];
  logic [OP_BITS-1:0] den_c [OP_BITS+1];
  logic               dbz_c [OP_BITS+1];

  assign v[0]      = s_axis_tvalid;
  assign rem_c[0]  = '0;
  assign work_c[0] = s_axis_tdata[OP_BITS-1:0];
  assign den_c[0]  = s_axis_tdata[FIELD_BITS +: OP_BITS];
  assign dbz_c[0]  = (s_axis_tdata[FIELD_BITS +: OP_BITS] == '0);
  assign s_axis_tready = rdy[0];

  for (genvar i = 0; i < OP_BITS; i++) begin : g_stage
    mrd_hs_t hs;
    assign hs = '{valid: v[i], ready: rdy[i]};

    mrd_stage #(
      .OP_BITS(OP_BITS)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .up        (hs),
      .up_ready  (rdy[i]),
      .rem_in    (rem_c[i]),
      .work_in   (work_c[i]),
      .den_in    (den_c[i]),
      .dbz_in    (dbz_c[i]),
      .down_valid(v[i+1]),
      .down_ready(rdy[i+1]),
      .rem       (rem_c[i+1]),
      .work      (work_c[i+1]),
      .den       (den_c[i+1]),
      .dbz       (dbz_c[i+1])
    );
  end

  assign rdy[OP_BITS]  = m_axis_tready;
  assign m_axis_tvalid = v[OP_BITS];
  assign m_axis_tdata  = {FIELD_BITS'(rem_c[OP_BITS]), FIELD_BITS'(work_c[OP_BITS])};
  assign m_axis_tuser  = dbz_c[OP_BITS];

endmodule
